/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of this project.
// With SYNTH defined every macro expands to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property that must hold at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Condition that must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	`ASSERT_PROP(label, clk, rst_n, !(cond))

`else

`define ASSERT_PROP(label, clk, rst_n, prop)

`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

/* hw/rtl/lnm_pkg.sv */
`timescale 1ns / 1ps

package lnm_pkg;

	// Field widths of the channels and registers.
	localparam int KEY_W      = 32;
	localparam int MASK_W     = 8;
	localparam int ROW_OUT_W  = 16;
	localparam int COL_OUT_W  = 10;
	localparam int NUM_ROWS_W = 16;
	localparam int NUM_COLS_W = 11;

	// Configuration port.
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam int REG_IDX_W  = 1;
	localparam logic [REG_IDX_W-1:0] REG_NUM_ROWS = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_NUM_COLS = 1'b1;

	// Neighbor bit positions in a mask.
	localparam int BIT_UP         = 0;
	localparam int BIT_RIGHT      = 1;
	localparam int BIT_DOWN       = 2;
	localparam int BIT_LEFT       = 3;
	localparam int BIT_UP_RIGHT   = 4;
	localparam int BIT_DOWN_RIGHT = 5;
	localparam int BIT_DOWN_LEFT  = 6;
	localparam int BIT_UP_LEFT    = 7;

	// Candidate slots of the masks one key can complete, in raster order.
	localparam int NUM_CAND   = 4;
	localparam int CAND_IDX_W = 2;
	localparam int CAND_UL    = 0;
	localparam int CAND_U     = 1;
	localparam int CAND_L     = 2;
	localparam int CAND_C     = 3;

	typedef struct packed {
		logic [KEY_W-1:0] key;
	} key_item_t;

	typedef struct packed {
		logic [ROW_OUT_W-1:0] row;
		logic [COL_OUT_W-1:0] col;
		logic [MASK_W-1:0]    lower_mask;
		logic                 run_end;
	} res_t;

	// Up to four finished masks handed from the core to the output buffer.
	typedef struct packed {
		logic [NUM_CAND-1:0]  en;
		res_t [NUM_CAND-1:0]  cand;
	} res_set_t;

	// Register contents and restart strobe for the core.
	typedef struct packed {
		logic [NUM_ROWS_W-1:0] num_rows;
		logic [NUM_COLS_W-1:0] num_cols;
		logic                  restart;
	} cfg_t;

endpackage

/* hw/rtl/lnm_stream_if.sv */
`timescale 1ns / 1ps

// Valid/ready channel carrying one item of type payload_t.
interface lnm_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/lnm_ram.sv */
`timescale 1ns / 1ps

// Simple dual-read RAM: one write port, two registered read ports.
// A read at the address being written returns the old contents.
module lnm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end
endmodule

/* hw/rtl/lnm_cfg_regs.sv */
`timescale 1ns / 1ps

// APB register file holding the grid size.
module lnm_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lnm_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [lnm_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [lnm_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	output lnm_pkg::cfg_t                   cfg
);
	import lnm_pkg::*;

	logic [NUM_ROWS_W-1:0] num_rows_q;
	logic [NUM_COLS_W-1:0] num_cols_q;
	logic [REG_IDX_W-1:0]  reg_idx;
	logic                  wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= NUM_ROWS_W'(1);
			num_cols_q <= NUM_COLS_W'(1);
		end else if (wr_en) begin
			case (reg_idx)
				REG_NUM_ROWS: num_rows_q <= pwdata[NUM_ROWS_W-1:0];
				REG_NUM_COLS: num_cols_q <= pwdata[NUM_COLS_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back.
	always_comb begin
		case (reg_idx)
			REG_NUM_ROWS: prdata = APB_DATA_W'(num_rows_q);
			REG_NUM_COLS: prdata = APB_DATA_W'(num_cols_q);
			default:      prdata = '0;
		endcase
	end

	// Any write restarts the frame.
	assign cfg.num_rows = num_rows_q;
	assign cfg.num_cols = num_cols_q;
	assign cfg.restart  = wr_en;
endmodule

/* hw/rtl/lnm_out_buf.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Result register: holds the masks finished by one key and hands them out
// one item per cycle while res_ch is ready, lowest raster position first.
module lnm_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  lnm_pkg::res_set_t   set_in,
	output logic                free,
	lnm_stream_if.source        res_ch
);
	import lnm_pkg::*;

	logic [NUM_CAND-1:0]   en_q;
	logic [NUM_CAND-1:0]   en_rest;
	res_t [NUM_CAND-1:0]   cand_q;
	logic [CAND_IDX_W-1:0] sel;
	logic                  out_fire;

	// Pick the lowest pending slot.
	always_comb begin
		sel = '0;
		for (int i = NUM_CAND - 1; i >= 0; i--) begin
			if (en_q[i]) begin
				sel = CAND_IDX_W'(i);
			end
		end
	end

	assign en_rest  = en_q & (en_q - NUM_CAND'(1));
	assign out_fire = res_ch.valid && res_ch.ready;
	assign free     = (en_q == '0) || (out_fire && (en_rest == '0));

	always_comb begin
		res_ch.valid        = (en_q != '0);
		res_ch.data         = cand_q[sel];
		res_ch.data.run_end = (en_rest == '0);
	end

	// Pending slots.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= '0;
		end else if (load) begin
			en_q <= set_in.en;
		end else if (out_fire) begin
			en_q <= en_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cand_q <= set_in.cand;
		end
	end

	`ASSERT_NEVER(a_load_while_busy, clk, arst_n, load && !free)
endmodule

/* hw/rtl/lnm_core.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Raster position, key/mask row store and the single compute stage.
module lnm_core #(
	parameter int MAX_COLS = 1024,
	parameter int MAX_ROWS = 65535
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lnm_pkg::cfg_t       cfg,
	lnm_stream_if.sink          key_ch,
	input  logic                set_free,
	output logic                set_load,
	output lnm_pkg::res_set_t   set_out
);
	import lnm_pkg::*;

	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int WORD_W = MASK_W + KEY_W;

	logic [COL_W-1:0]  col_last;
	logic [ROW_W-1:0]  row_last;
	logic [COL_W-1:0]  pos_col_q;
	logic [ROW_W-1:0]  pos_row_q;
	logic [COL_W-1:0]  rd_addr1;
	logic              pos_last_col;
	logic              pos_last_row;
	logic              accept;
	logic              s1_fire;
	logic              s1_v_q;
	logic              fwd0;
	logic              fwd1;

	logic [KEY_W-1:0]  key_s1;
	logic [ROW_W-1:0]  row_s1;
	logic [COL_W-1:0]  col_s1;
	logic              last_row_s1;
	logic              last_col_s1;
	logic              fwd0_s1;
	logic              fwd1_s1;
	logic [WORD_W-1:0] fwd_word_s1;

	logic [WORD_W-1:0] rd_data0;
	logic [WORD_W-1:0] rd_data1;
	logic [WORD_W-1:0] u_word;
	logic [WORD_W-1:0] ur_word;
	logic [WORD_W-1:0] wr_word;
	logic [KEY_W-1:0]  u_key;
	logic [KEY_W-1:0]  ur_key;
	logic [MASK_W-1:0] u_mask;

	logic [KEY_W-1:0]  left_q;
	logic [KEY_W-1:0]  left2_q;
	logic [KEY_W-1:0]  ul_key_q;
	logic [MASK_W-1:0] ul_mask_q;
	logic [MASK_W-1:0] prev_m_q;

	logic              has_up;
	logic              has_left;
	logic              has_left2;
	logic              has_right;
	logic              lk;
	logic              uk;
	logic              ulk;
	logic              urk;
	logic              ul_u;
	logic              ul_l;
	logic              ul_l2;
	logic              u_l;
	logic [MASK_W-1:0] mask_new;
	logic [ROW_OUT_W-1:0] row_up;
	logic [ROW_OUT_W-1:0] row_cur;
	logic [COL_OUT_W-1:0] col_left;
	logic [COL_OUT_W-1:0] col_cur;

	// Effective last row and column: zero acts as one, large values clip.
	always_comb begin
		if (cfg.num_rows == '0) begin
			row_last = '0;
		end else if (32'(cfg.num_rows) > 32'(MAX_ROWS)) begin
			row_last = ROW_W'(MAX_ROWS - 1);
		end else begin
			row_last = ROW_W'(32'(cfg.num_rows) - 32'd1);
		end
		if (cfg.num_cols == '0) begin
			col_last = '0;
		end else if (32'(cfg.num_cols) > 32'(MAX_COLS)) begin
			col_last = COL_W'(MAX_COLS - 1);
		end else begin
			col_last = COL_W'(32'(cfg.num_cols) - 32'd1);
		end
	end

	assign pos_last_col = (pos_col_q == col_last);
	assign pos_last_row = (pos_row_q == row_last);
	assign key_ch.ready = !s1_v_q || s1_fire;
	assign accept       = key_ch.valid && key_ch.ready;

	// Raster position of the next key.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_col_q <= '0;
			pos_row_q <= '0;
		end else if (cfg.restart) begin
			pos_col_q <= '0;
			pos_row_q <= '0;
		end else if (accept) begin
			if (pos_last_col) begin
				pos_col_q <= '0;
				pos_row_q <= pos_last_row ? '0 : pos_row_q + ROW_W'(1);
			end else begin
				pos_col_q <= pos_col_q + COL_W'(1);
			end
		end
	end

	// Row store: previous-row key and its own-step mask bits per column.
	// The stage writes its column while the next key reads two columns;
	// a read of the column being written takes the new word instead.
	assign rd_addr1 = pos_col_q + COL_W'(1);
	assign wr_word  = {mask_new, key_s1};
	assign fwd0     = s1_fire && (col_s1 == pos_col_q);
	assign fwd1     = s1_fire && (col_s1 == rd_addr1);

	lnm_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_COLS)
	) u_row_ram (
		.clk   (clk),
		.we    (s1_fire),
		.waddr (col_s1),
		.wdata (wr_word),
		.re    (accept),
		.raddr0(pos_col_q),
		.raddr1(rd_addr1),
		.rdata0(rd_data0),
		.rdata1(rd_data1)
	);

	// Stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (accept) begin
			s1_v_q <= 1'b1;
		end else if (s1_fire) begin
			s1_v_q <= 1'b0;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_s1      <= key_ch.data.key;
			row_s1      <= pos_row_q;
			col_s1      <= pos_col_q;
			last_row_s1 <= pos_last_row;
			last_col_s1 <= pos_last_col;
			fwd0_s1     <= fwd0;
			fwd1_s1     <= fwd1;
			fwd_word_s1 <= wr_word;
		end
	end

	assign u_word  = fwd0_s1 ? fwd_word_s1 : rd_data0;
	assign ur_word = fwd1_s1 ? fwd_word_s1 : rd_data1;
	assign u_key   = u_word[KEY_W-1:0];
	assign u_mask  = u_word[WORD_W-1:KEY_W];
	assign ur_key  = ur_word[KEY_W-1:0];

	assign has_up    = (row_s1 != '0);
	assign has_left  = (col_s1 != '0);
	assign has_left2 = (col_s1 > COL_W'(1));
	assign has_right = !last_col_s1;

	// Key comparisons: the earlier vertex precedes on an equal key.
	assign lk    = (left_q <= key_s1);
	assign uk    = (u_key <= key_s1);
	assign ulk   = (ul_key_q <= key_s1);
	assign urk   = (ur_key <= key_s1);
	assign ul_u  = (ul_key_q <= u_key);
	assign ul_l  = (ul_key_q <= left_q);
	assign ul_l2 = (ul_key_q <= left2_q);
	assign u_l   = (u_key <= left_q);

	// Bits of the new vertex that come from earlier neighbors.
	always_comb begin
		mask_new               = '0;
		mask_new[BIT_LEFT]     = has_left && lk;
		mask_new[BIT_UP]       = has_up && uk;
		mask_new[BIT_UP_LEFT]  = has_up && has_left && ulk;
		mask_new[BIT_UP_RIGHT] = has_up && has_right && urk;
	end

	assign row_up   = ROW_OUT_W'(row_s1 - ROW_W'(1));
	assign row_cur  = ROW_OUT_W'(row_s1);
	assign col_left = COL_OUT_W'(col_s1 - COL_W'(1));
	assign col_cur  = COL_OUT_W'(col_s1);

	// Masks finished by this key. The bits toward later neighbors are
	// rebuilt from the key window instead of being stored.
	always_comb begin
		set_out = '0;

		set_out.en[CAND_UL]                              = has_up && has_left;
		set_out.cand[CAND_UL].row                        = row_up;
		set_out.cand[CAND_UL].col                        = col_left;
		set_out.cand[CAND_UL].lower_mask                 = ul_mask_q;
		set_out.cand[CAND_UL].lower_mask[BIT_RIGHT]      = !ul_u;
		set_out.cand[CAND_UL].lower_mask[BIT_DOWN]       = !ul_l;
		set_out.cand[CAND_UL].lower_mask[BIT_DOWN_RIGHT] = !ulk;
		set_out.cand[CAND_UL].lower_mask[BIT_DOWN_LEFT]  = has_left2 && !ul_l2;

		set_out.en[CAND_U]                               = has_up && last_col_s1;
		set_out.cand[CAND_U].row                         = row_up;
		set_out.cand[CAND_U].col                         = col_cur;
		set_out.cand[CAND_U].lower_mask                  = u_mask;
		set_out.cand[CAND_U].lower_mask[BIT_DOWN]        = !uk;
		set_out.cand[CAND_U].lower_mask[BIT_DOWN_LEFT]   = has_left && !u_l;

		set_out.en[CAND_L]                               = has_left && last_row_s1;
		set_out.cand[CAND_L].row                         = row_cur;
		set_out.cand[CAND_L].col                         = col_left;
		set_out.cand[CAND_L].lower_mask                  = prev_m_q;
		set_out.cand[CAND_L].lower_mask[BIT_RIGHT]       = !lk;

		set_out.en[CAND_C]                               = last_row_s1 && last_col_s1;
		set_out.cand[CAND_C].row                         = row_cur;
		set_out.cand[CAND_C].col                         = col_cur;
		set_out.cand[CAND_C].lower_mask                  = mask_new;
	end

	// The stage retires when its masks fit into the result register.
	assign s1_fire  = s1_v_q && ((set_out.en == '0) || set_free);
	assign set_load = s1_v_q && (set_out.en != '0) && set_free;

	// Keys of the current row to the left.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			left2_q <= '0;
		end else if (cfg.restart) begin
			left_q  <= '0;
			left2_q <= '0;
		end else if (s1_fire) begin
			left_q  <= key_s1;
			left2_q <= left_q;
		end
	end

	// Up-left window entry and the previous vertex's own bits.
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			ul_key_q  <= u_key;
			ul_mask_q <= u_mask;
			prev_m_q  <= mask_new;
		end
	end

	`ASSERT_NEVER(a_accept_over_busy_stage, clk, arst_n, accept && s1_v_q && !s1_fire)
	`ASSERT_NEVER(a_col_in_frame, clk, arst_n, pos_col_q > col_last)
	`ASSERT_NEVER(a_row_in_frame, clk, arst_n, pos_row_q > row_last)
endmodule

/* hw/rtl/lower_neighbor_mask_2d.sv */
`timescale 1ns / 1ps

// Lower-neighbor masks on an 8-connected grid. Keys arrive one item per
// vertex in raster order on key_ch; for each vertex res_ch gives its row,
// column and an 8-bit mask of the neighbors that precede it (smaller key,
// or equal key earlier in raster order), bits 0 up, 1 right, 2 down,
// 3 left, 4 up-right, 5 down-right, 6 down-left, 7 up-left. A mask leaves
// once its last neighbor has arrived, so one key yields zero to four
// items, the last flagged by run_end. With the receiver always ready a key
// is accepted every cycle as long as each key yields at most one mask,
// which holds away from the last row and the last column. The result
// register hands out one item per cycle while res_ch is ready, so after
// a key that yields more than one mask the next key that yields any
// waits in the stage until the last is taken; the input waits too. Each
// key is held in the stage, its masks in the result register. The grid is
// num_rows by num_cols (register 0 at byte 0, register 1 at byte 4); zero
// acts as one, larger values clip to MAX_ROWS and MAX_COLS. Write the
// registers only while the block is idle; every write restarts at row 0,
// column 0. One row of keys and masks sits in a MAX_COLS-deep RAM that
// needs no clearing after reset.
module lower_neighbor_mask_2d #(
	parameter int MAX_COLS = 1024,
	parameter int MAX_ROWS = 65535
) (
	input  logic                            clk,
	input  logic                            arst_n,
	lnm_stream_if.sink                      key_ch,
	lnm_stream_if.source                    res_ch,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lnm_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [lnm_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [lnm_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);
	import lnm_pkg::*;

	cfg_t     cfg;
	res_set_t set;
	logic     set_free;
	logic     set_load;

	lnm_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	lnm_core #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.key_ch  (key_ch),
		.set_free(set_free),
		.set_load(set_load),
		.set_out (set)
	);

	lnm_out_buf u_out_buf (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (set_load),
		.set_in(set),
		.free  (set_free),
		.res_ch(res_ch)
	);
endmodule

/* dv/lnm_mask_checker.sv */
`timescale 1ns / 1ps

// Watches the key, mask and register traffic around lower_neighbor_mask_2d.
// It keeps its own copy of the grid state, works out the masks that every
// accepted key completes, and compares each mask item with the oldest one
// still waiting. It also checks register reads against the values written.
module lnm_mask_checker #(
	parameter int MAX_COLS = 1024,
	parameter int MAX_ROWS = 65535
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           key_valid,
	input  logic                           key_ready,
	input  lnm_pkg::key_item_t             key_data,
	input  logic                           res_valid,
	input  logic                           res_ready,
	input  lnm_pkg::res_t                  res_data,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic                           pready,
	input  logic [lnm_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [lnm_pkg::APB_DATA_W-1:0] pwdata,
	input  logic [lnm_pkg::APB_DATA_W-1:0] prdata,
	output int                             fail_count,
	output int                             pending,
	output int                             masks_checked
);
	import lnm_pkg::*;

	// Shadow of the block: keys of the row above, masks of two rows, grid size.
	logic [KEY_W-1:0]      upper_keys [MAX_COLS];
	logic [MASK_W-1:0]     mask_rows [2*MAX_COLS];
	logic [KEY_W-1:0]      left_key;
	int unsigned           row_pos;
	int unsigned           col_pos;
	logic [NUM_ROWS_W-1:0] num_rows;
	logic [NUM_COLS_W-1:0] num_cols;
	res_t                  expected_masks [$];

	function automatic res_t make_mask_item(input int unsigned r, input int unsigned c,
			input logic [MASK_W-1:0] m);
		res_t item;
		item.row        = ROW_OUT_W'(r);
		item.col        = COL_OUT_W'(c);
		item.lower_mask = m;
		item.run_end    = 1'b0;
		return item;
	endfunction

	// Apply one key: compare it with its four earlier neighbors, then queue
	// every mask that this key completes, in raster order.
	task automatic predict_masks(input logic [KEY_W-1:0] k);
		int unsigned       rows;
		int unsigned       cols;
		int unsigned       r;
		int unsigned       c;
		int unsigned       cur;
		int unsigned       prv;
		logic [MASK_W-1:0] m;
		res_t              finished [$];

		// A zero size acts as one; oversized grids clip to MAX_ROWS and MAX_COLS.
		rows = (num_rows == 0) ? 1 : num_rows;
		if (rows > MAX_ROWS) rows = MAX_ROWS;
		cols = (num_cols == 0) ? 1 : num_cols;
		if (cols > MAX_COLS) cols = MAX_COLS;
		if (row_pos >= rows || col_pos >= cols) begin
			row_pos = 0;
			col_pos = 0;
		end
		r   = row_pos;
		c   = col_pos;
		cur = (r % 2) * MAX_COLS;
		prv = ((r + 1) % 2) * MAX_COLS;
		m   = '0;

		// Of each pair, the later vertex gets the bit if the earlier one
		// precedes it; otherwise the earlier vertex gets the opposite bit.
		if (c >= 1) begin
			if (left_key <= k) m[BIT_LEFT] = 1'b1;
			else mask_rows[cur + c - 1][BIT_RIGHT] = 1'b1;
		end
		if (r >= 1) begin
			if (upper_keys[c] <= k) m[BIT_UP] = 1'b1;
			else mask_rows[prv + c][BIT_DOWN] = 1'b1;
			if (c >= 1) begin
				if (upper_keys[c - 1] <= k) m[BIT_UP_LEFT] = 1'b1;
				else mask_rows[prv + c - 1][BIT_DOWN_RIGHT] = 1'b1;
			end
			if (c + 1 < cols) begin
				if (upper_keys[c + 1] <= k) m[BIT_UP_RIGHT] = 1'b1;
				else mask_rows[prv + c + 1][BIT_DOWN_LEFT] = 1'b1;
			end
		end
		mask_rows[cur + c] = m;

		// The key of the left vertex moves up one step late, so the up-left
		// key is still in place for the next key.
		if (c >= 1) upper_keys[c - 1] = left_key;
		if (c + 1 == cols) upper_keys[c] = k;
		left_key = k;

		if (r >= 1 && c >= 1)
			finished.push_back(make_mask_item(r - 1, c - 1, mask_rows[prv + c - 1]));
		if (r >= 1 && c + 1 == cols)
			finished.push_back(make_mask_item(r - 1, c, mask_rows[prv + c]));
		if (c >= 1 && r + 1 == rows)
			finished.push_back(make_mask_item(r, c - 1, mask_rows[cur + c - 1]));
		if (r + 1 == rows && c + 1 == cols)
			finished.push_back(make_mask_item(r, c, mask_rows[cur + c]));
		if (finished.size() > 0) finished[finished.size() - 1].run_end = 1'b1;
		foreach (finished[i]) expected_masks.push_back(finished[i]);

		if (c + 1 < cols) begin
			col_pos = c + 1;
		end else begin
			col_pos = 0;
			row_pos = (r + 1 < rows) ? r + 1 : 0;
		end
	endtask

	task automatic compare_mask(input res_t got);
		res_t want;
		logic bad;

		if (expected_masks.size() == 0) begin
			$display("%0t: mask item with none expected: row %0d col %0d mask %02h run_end %0b",
				$time, got.row, got.col, got.lower_mask, got.run_end);
			fail_count++;
			return;
		end
		want = expected_masks.pop_front();
		masks_checked++;
		bad = 1'b0;
		if (got.row !== want.row) begin
			$display("%0t: row mismatch: expected %0d, actual %0d", $time, want.row, got.row);
			bad = 1'b1;
		end
		if (got.col !== want.col) begin
			$display("%0t: col mismatch: expected %0d, actual %0d", $time, want.col, got.col);
			bad = 1'b1;
		end
		if (got.lower_mask !== want.lower_mask) begin
			$display("%0t: lower_mask mismatch at (%0d,%0d): expected %02h, actual %02h",
				$time, want.row, want.col, want.lower_mask, got.lower_mask);
			bad = 1'b1;
		end
		if (got.run_end !== want.run_end) begin
			$display("%0t: run_end mismatch at (%0d,%0d): expected %0b, actual %0b",
				$time, want.row, want.col, want.run_end, got.run_end);
			bad = 1'b1;
		end
		if (bad) fail_count++;
	endtask

	// Register access: a write restarts the frame, a read must return the value.
	task automatic register_access();
		logic [REG_IDX_W-1:0]  idx;
		logic [APB_DATA_W-1:0] want;

		idx = paddr[2 +: REG_IDX_W];
		if (pwrite) begin
			if (idx == REG_NUM_ROWS) num_rows = pwdata[NUM_ROWS_W-1:0];
			else num_cols = pwdata[NUM_COLS_W-1:0];
			row_pos  = 0;
			col_pos  = 0;
			left_key = '0;
		end else begin
			want = (idx == REG_NUM_ROWS) ? APB_DATA_W'(num_rows) : APB_DATA_W'(num_cols);
			if (prdata !== want) begin
				$display("%0t: register %0d read mismatch: expected %0h, actual %0h",
					$time, idx, want, prdata);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_key      = '0;
			row_pos       = 0;
			col_pos       = 0;
			num_rows      = 1;
			num_cols      = 1;
			expected_masks.delete();
			fail_count    = 0;
			pending       = 0;
			masks_checked = 0;
		end else begin
			// A mask leaves after its key passes the stage and result registers, so
			// results are checked before this edge's key is applied.
			if (res_valid && res_ready) compare_mask(res_data);
			if (psel && penable && pready) register_access();
			if (key_valid && key_ready) predict_masks(key_data.key);
			pending = expected_masks.size();
		end
	end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
	import lnm_pkg::*;

	localparam int MAX_COLS      = 1024;
	localparam int MAX_ROWS      = 65535;
	localparam int CYCLE_LIMIT   = 200_000;
	localparam int SETTLE_CYCLES = 8;

	typedef enum int {
		KEYS_RANDOM,
		KEYS_TIES,
		KEYS_RISING,
		KEYS_FALLING,
		KEYS_EXTREMES
	} key_style_e;

	typedef enum int {
		SINK_OPEN,
		SINK_COIN,
		SINK_EVERY4,
		SINK_LONG
	} sink_mode_e;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int                    fail_count;
	int                    pending;
	int                    masks_checked;
	int                    keys_sent;
	int                    settings_used;
	int                    cycles;
	logic [KEY_W-1:0]      last_key;

	sink_mode_e            sink_mode;
	int                    mode_left;
	int                    stall_left;
	int                    sink_count;

	lnm_stream_if #(.payload_t(key_item_t)) key_ch ();
	lnm_stream_if #(.payload_t(res_t))      res_ch ();

	lower_neighbor_mask_2d #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.key_ch  (key_ch),
		.res_ch  (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	lnm_mask_checker #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) mask_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.key_valid     (key_ch.valid),
		.key_ready     (key_ch.ready),
		.key_data      (key_ch.data),
		.res_valid     (res_ch.valid),
		.res_ready     (res_ch.ready),
		.res_data      (res_ch.data),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.fail_count    (fail_count),
		.pending       (pending),
		.masks_checked (masks_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs or masks go missing.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d masks outstanding", cycles, pending);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Mask receiver: the stall pattern changes at random times between
	// always ready, coin flips, a fixed one-in-four stall and long stalls.
	always @(negedge clk) begin
		if (mode_left == 0) begin
			sink_mode = sink_mode_e'($urandom_range(SINK_OPEN, SINK_LONG));
			mode_left = $urandom_range(20, 80);
		end else begin
			mode_left--;
		end
		sink_count++;
		if (stall_left > 0) begin
			stall_left--;
			res_ch.ready <= 1'b0;
		end else begin
			case (sink_mode)
				SINK_OPEN: res_ch.ready <= 1'b1;
				SINK_COIN: res_ch.ready <= 1'($urandom_range(0, 1));
				SINK_EVERY4: res_ch.ready <= (sink_count % 4 != 3);
				default: begin
					if ($urandom_range(0, 7) == 0) begin
						stall_left = $urandom_range(3, 12);
						res_ch.ready <= 1'b0;
					end else begin
						res_ch.ready <= 1'b1;
					end
				end
			endcase
		end
	end

	function automatic logic [KEY_W-1:0] next_key(input key_style_e style);
		case (style)
			KEYS_TIES: last_key = KEY_W'($urandom_range(0, 3));
			KEYS_RISING: last_key = last_key + KEY_W'($urandom_range(0, 2));
			KEYS_FALLING: last_key = last_key - KEY_W'($urandom_range(0, 2));
			KEYS_EXTREMES: begin
				case ($urandom_range(0, 4))
					0: last_key = '0;
					1: last_key = '1;
					2: last_key = 32'h8000_0000;
					3: last_key = 32'h7FFF_FFFF;
					default: last_key = $urandom;
				endcase
			end
			default: last_key = $urandom;
		endcase
		return last_key;
	endfunction

	// One APB transfer: setup cycle, then access until pready.
	task automatic apb_access(input logic wr, input logic [REG_IDX_W-1:0] idx,
			input logic [APB_DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= APB_ADDR_W'(idx) << 2;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Holds the key and returns at the edge that accepts it.
	task automatic send_key(input logic [KEY_W-1:0] k);
		@(negedge clk);
		key_ch.valid    <= 1'b1;
		key_ch.data.key <= k;
		do @(posedge clk); while (!key_ch.ready);
		keys_sent++;
	endtask

	task automatic idle_gap(input int n);
		@(negedge clk);
		key_ch.valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// Stop sending and wait until every predicted mask has come out, then a
	// settling wait for keys that complete no mask.
	task automatic wait_drain();
		@(negedge clk);
		key_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Sends n keys in bursts of random length with random gaps between them.
	task automatic send_stream(input int n, input key_style_e style, input int pause_at);
		int burst;

		burst = $urandom_range(1, 24);
		for (int i = 0; i < n; i++) begin
			if (i == pause_at) begin
				wait_drain();
			end else if (burst == 0) begin
				burst = $urandom_range(1, 24);
				if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 6));
			end
			if (burst > 0) burst--;
			send_key(next_key(style));
		end
	endtask

	// New grid size while the block is idle, read back, then a stream of keys.
	task automatic run_grid(input logic [APB_DATA_W-1:0] rows_word,
			input logic [APB_DATA_W-1:0] cols_word, input logic set_rows, input int n,
			input key_style_e style, input int pause_at);
		wait_drain();
		if ($urandom_range(0, 1)) begin
			if (set_rows) apb_access(1'b1, REG_NUM_ROWS, rows_word);
			apb_access(1'b1, REG_NUM_COLS, cols_word);
		end else begin
			apb_access(1'b1, REG_NUM_COLS, cols_word);
			if (set_rows) apb_access(1'b1, REG_NUM_ROWS, rows_word);
		end
		apb_access(1'b0, REG_NUM_ROWS, '0);
		apb_access(1'b0, REG_NUM_COLS, '0);
		settings_used++;
		send_stream(n, style, pause_at);
	endtask

	initial begin : stimulus
		logic [KEY_W-1:0] corner_keys [14];
		int rows;
		int cols;
		int frame;
		int n;
		int pause_at;

		corner_keys     = '{
			32'd5, 32'd5, 32'd5, 32'd0,
			32'hFFFF_FFFF, 32'd5, 32'h7FFF_FFFF, 32'h8000_0000,
			32'd0, 32'd5, 32'd5, 32'hFFFF_FFFF,
			32'd1, 32'd1
		};
		arst_n          = 1'b0;
		key_ch.valid    = 1'b0;
		key_ch.data     = '0;
		res_ch.ready    = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		cycles          = 0;
		keys_sent       = 0;
		settings_used   = 1;
		last_key        = '0;
		sink_mode       = SINK_OPEN;
		mode_left       = 0;
		stall_left      = 0;
		sink_count      = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset grid is one vertex: every key is its own frame.
		apb_access(1'b0, REG_NUM_ROWS, '0);
		apb_access(1'b0, REG_NUM_COLS, '0);
		send_key('0);
		send_key('1);
		wait_drain();

		// A 3x4 frame with ties and extreme keys reaches every neighbor
		// direction, then wraps into the next frame.
		apb_access(1'b1, REG_NUM_ROWS, 32'd3);
		apb_access(1'b1, REG_NUM_COLS, 32'd4);
		settings_used++;
		foreach (corner_keys[i]) send_key(corner_keys[i]);
		wait_drain();

		// Zero sizes act as one; the upper bits of the written word are ignored.
		apb_access(1'b1, REG_NUM_ROWS, 32'hFFFF_0000);
		apb_access(1'b1, REG_NUM_COLS, 32'hFFFF_F800);
		apb_access(1'b0, REG_NUM_ROWS, '0);
		apb_access(1'b0, REG_NUM_COLS, '0);
		settings_used++;
		send_key(32'h0000_FFFF);
		send_key(32'hFFFF_0000);
		send_key(32'h5555_AAAA);

		// Small grids with random content; one phase pauses mid-stream until
		// all masks are out, others may.
		for (int phase = 0; phase < 7; phase++) begin
			rows  = $urandom_range(1, 6);
			cols  = $urandom_range(1, 12);
			frame = rows * cols;
			n     = frame * $urandom_range(1, 2) + $urandom_range(0, frame);
			if (phase == 0 || $urandom_range(0, 2) == 0) pause_at = $urandom_range(1, n);
			else pause_at = -1;
			run_grid(APB_DATA_W'(rows) | ($urandom & 32'hFFFF_0000),
				APB_DATA_W'(cols) | ($urandom & 32'hFFFF_F800),
				phase == 0 || $urandom_range(0, 3) != 0, n,
				key_style_e'(phase % 5), pause_at);
		end

		// One row of 2047 columns, which clip to the store depth.
		run_grid(32'd1, 32'd2047, 1'b1, 16, KEYS_TIES, 8);

		wait_drain();
		repeat (20) @(negedge clk);

		$display("Run covered %0d keys over %0d grid sizes, from one vertex up to",
			keys_sent, settings_used);
		$display("6x12 grids and a clipped 2047-column row; %0d mask items were compared.",
			masks_checked);
		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
